// ===== rtl/core/skf_pkg.sv =====
// skf_pkg: shared types, constants and the microcode program of the scalar kalman filter
// no dependencies; imported by the configuration channel interface, the divider and the top level
package skf_pkg;

  // widths fixed by the data formats
  localparam int PC_W       = 4;
  localparam int STEP_W     = 6;
  localparam int REM_W      = 34;
  localparam int CFG_ADDR_W = 2;

  // quotient bits produced for a restart variance
  localparam logic [STEP_W-1:0] DIV_STEPS_RST = 6'd32;

  // configuration registers: reset value is 1.0 in q16.16
  localparam logic [31:0] REG_RESET = 32'h0001_0000;

  localparam logic [CFG_ADDR_W-1:0] CFG_START_VAR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROC_NOISE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_NOISE = 2'd2;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_RP,   // r * p0
    MUL_EG,   // error * gain
    MUL_RG    // r * gain
  } mul_sel_t;

  // divider launch
  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_RST,  // r*p0 / (p0+r)
    DIV_OBS   // pp*2^f / (pp+r)
  } div_sel_t;

  // register write selection
  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,     // estimate and previous estimate take the start value
    WR_VAR_DIV,  // variance from the quotient
    WR_GAIN,     // gain from the quotient
    WR_EST,      // estimate step
    WR_VAR_MUL,  // variance from r * gain
    WR_PRED,     // 2x - x_prev
    WR_OUT       // result register
  } wr_sel_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_OBS,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  // program addresses
  localparam logic [PC_W-1:0] A_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] A_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] A_RST_LOAD = 4'd2;
  localparam logic [PC_W-1:0] A_RST_DIV  = 4'd3;
  localparam logic [PC_W-1:0] A_RST_WAIT = 4'd4;
  localparam logic [PC_W-1:0] A_RST_VAR  = 4'd5;
  localparam logic [PC_W-1:0] A_OBS_DIV  = 4'd6;
  localparam logic [PC_W-1:0] A_OBS_WAIT = 4'd7;
  localparam logic [PC_W-1:0] A_OBS_GAIN = 4'd8;
  localparam logic [PC_W-1:0] A_OBS_MUL  = 4'd9;
  localparam logic [PC_W-1:0] A_OBS_EST  = 4'd10;
  localparam logic [PC_W-1:0] A_OBS_VAR  = 4'd11;
  localparam logic [PC_W-1:0] A_PRED     = 4'd12;
  localparam logic [PC_W-1:0] A_OUT      = 4'd13;
  localparam logic [PC_W-1:0] A_DONE     = 4'd14;

  // one control word
  typedef struct packed {
    logic            accept;
    mul_sel_t        mul;
    div_sel_t        div;
    wr_sel_t         wr;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // divider launch request
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  function automatic ucode_t mk_word(input logic accept, input mul_sel_t mul,
                                     input div_sel_t div, input wr_sel_t wr,
                                     input cond_t cond, input logic [PC_W-1:0] target);
    ucode_t w;
    w.accept = accept;
    w.mul    = mul;
    w.div    = div;
    w.wr     = wr;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // microcode rom: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      A_IDLE:     w = mk_word(1'b1, MUL_NONE, DIV_NONE, WR_NONE,    C_NO_ITEM,  A_IDLE);
      A_DISPATCH: w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_NONE,    C_OBS,      A_OBS_DIV);
      A_RST_LOAD: w = mk_word(1'b0, MUL_RP,   DIV_NONE, WR_LOAD,    C_NEVER,    A_IDLE);
      A_RST_DIV:  w = mk_word(1'b0, MUL_NONE, DIV_RST,  WR_NONE,    C_NEVER,    A_IDLE);
      A_RST_WAIT: w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_NONE,    C_DIV_BUSY, A_RST_WAIT);
      A_RST_VAR:  w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_VAR_DIV, C_ALWAYS,   A_PRED);
      A_OBS_DIV:  w = mk_word(1'b0, MUL_NONE, DIV_OBS,  WR_NONE,    C_NEVER,    A_IDLE);
      A_OBS_WAIT: w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_NONE,    C_DIV_BUSY, A_OBS_WAIT);
      A_OBS_GAIN: w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_GAIN,    C_NEVER,    A_IDLE);
      A_OBS_MUL:  w = mk_word(1'b0, MUL_EG,   DIV_NONE, WR_NONE,    C_NEVER,    A_IDLE);
      A_OBS_EST:  w = mk_word(1'b0, MUL_RG,   DIV_NONE, WR_EST,     C_NEVER,    A_IDLE);
      A_OBS_VAR:  w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_VAR_MUL, C_NEVER,    A_IDLE);
      A_PRED:     w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_PRED,    C_NEVER,    A_IDLE);
      A_OUT:      w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_OUT,     C_OUT_BUSY, A_OUT);
      A_DONE:     w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_NONE,    C_ALWAYS,   A_IDLE);
      default:    w = mk_word(1'b0, MUL_NONE, DIV_NONE, WR_NONE,    C_ALWAYS,   A_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/skf_in_if.sv =====
// skf_in_if: input item channel of the scalar kalman filter (kind, value)
// no dependencies
interface skf_in_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/core/skf_out_if.sv =====
// skf_out_if: result item channel of the scalar kalman filter (estimate, prediction)
// no dependencies
interface skf_out_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] estimate;
  logic signed [VALUE_BITS-1:0] prediction;

  modport source (output valid, output estimate, output prediction, input ready);
  modport sink   (input valid, input estimate, input prediction, output ready);
endinterface

// ===== rtl/core/skf_cfg_if.sv =====
// skf_cfg_if: register write channel of the scalar kalman filter
// depends on skf_pkg for the address width
interface skf_cfg_if import skf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [31:0]           data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/skf_div.sv =====
// skf_div: restoring divider, one quotient bit per cycle, shared by both filter paths
// depends on skf_pkg (div_req_t, REM_W, STEP_W)
module skf_div import skf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [REM_W-1:0] dividend_hi,
  input  logic [31:0]      dividend_lo,
  input  logic [REM_W-1:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);

  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  den_r;
  logic [31:0]       sh_r;

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              fits;

  // one trial subtraction
  always_comb begin
    trial = {rem_r, sh_r[31]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.steps;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= dividend_hi;
      sh_r  <= dividend_lo;
      den_r <= divisor;
    end else if (busy) begin
      rem_r <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      sh_r  <= {sh_r[30:0], fits};
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = sh_r;

endmodule

// ===== rtl/core/scalar_kalman_filter.sv =====
// scalar_kalman_filter: q16.16 random-walk kalman filter run by a microcoded sequencer
// depends on skf_pkg, skf_in_if, skf_out_if, skf_cfg_if and skf_div
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------
//  in_ch   | in  | valid/ready  | kind (1b), value (VALUE_BITS signed)
//  out_ch  | out | valid/ready  | estimate, prediction (VALUE_BITS signed)
//  cfg_ch  | in  | valid/ready  | addr (2b: p0, q, r), data (32b); always ready
//
// an item runs its steps from accept to the next accept; the divider, one quotient
// bit a cycle, works within both the restart and the observation steps. the result
// waits in an output register, so the next item is taken while it is pending; a
// stalled result holds the sequencer at its output step.
// reset is synchronous: registers go to 1.0, the filter state to zero.
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);

  localparam int GAIN_W = FRAC_BITS + 1;
  localparam logic signed [63:0] W32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] W32_MIN  = -64'sd2147483648;
  localparam logic signed [65:0] RND_66   = (66'sd1 <<< FRAC_BITS) - 66'sd1;
  localparam logic signed [33:0] RND_34   = (34'sd1 <<< FRAC_BITS) - 34'sd1;
  localparam logic signed [33:0] VAL_MAX  = (34'sd1 <<< (VALUE_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] VAL_MIN  = -VAL_MAX - 34'sd1;
  localparam logic [STEP_W-1:0]  OBS_STEPS = STEP_W'(FRAC_BITS + 1);

  // truncate toward zero to an integer and saturate
  function automatic logic signed [VALUE_BITS-1:0] to_out(input logic signed [33:0] fix);
    logic signed [33:0] adj;
    logic signed [33:0] whole;
    logic signed [33:0] sat;
    adj   = fix + (fix[33] ? RND_34 : 34'sd0);
    whole = adj >>> FRAC_BITS;
    if (whole > VAL_MAX) begin
      sat = VAL_MAX;
    end else if (whole < VAL_MIN) begin
      sat = VAL_MIN;
    end else begin
      sat = whole;
    end
    return sat[VALUE_BITS-1:0];
  endfunction

  // sequencer
  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_t          cw;
  logic            take;

  // configuration
  logic [31:0] p0_r;
  logic [31:0] q_r;
  logic [31:0] r_r;

  // filter state and working registers
  logic signed [31:0]   x_r;
  logic signed [31:0]   xp_r;
  logic [31:0]          var_r;
  logic                 kind_r;
  logic signed [31:0]   obs_r;
  logic [GAIN_W-1:0]    gain_r;
  logic signed [65:0]   prod_r;
  logic signed [33:0]   pred_r;
  logic                 den_zero_r;

  // result register
  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_est_r;
  logic signed [VALUE_BITS-1:0] out_pred_r;

  // datapath nets
  logic                 in_acc;
  logic                 out_busy;
  logic signed [63:0]   val_wide;
  logic signed [31:0]   obs_fix;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [32:0]   obs_ext;
  logic signed [32:0]   x_ext;
  logic signed [32:0]   err;
  logic [32:0]          rst_den;
  logic [32:0]          pp;
  logic [33:0]          obs_den;
  logic signed [65:0]   prod_adj;
  logic signed [65:0]   step_wide;
  logic [32:0]          x_sum;
  logic [33:0]          pred_val;

  // divider hookup
  div_req_t         div_req;
  logic [REM_W-1:0] div_hi;
  logic [31:0]      div_lo;
  logic [REM_W-1:0] div_den;
  logic             div_busy;
  logic [31:0]      div_quo;

  // control word fetch and jump decision
  always_comb begin
    cw       = ucode_rom(pc_r);
    in_acc   = in_ch.valid && cw.accept;
    out_busy = out_valid_r && !out_ch.ready;
    case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_ITEM:  take = !in_acc;
      C_OBS:      take = kind_r;
      C_DIV_BUSY: take = div_busy;
      C_OUT_BUSY: take = out_busy;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? cw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r <= REG_RESET;
      q_r  <= REG_RESET;
      r_r  <= REG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_START_VAR:  p0_r <= cfg_ch.data;
        CFG_PROC_NOISE: q_r  <= cfg_ch.data;
        CFG_MEAS_NOISE: r_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input value to fixed point, saturated to 32 bits
  always_comb begin
    val_wide = {{(64-VALUE_BITS){in_ch.value[VALUE_BITS-1]}}, in_ch.value} <<< FRAC_BITS;
    if (val_wide > W32_MAX) begin
      obs_fix = W32_MAX[31:0];
    end else if (val_wide < W32_MIN) begin
      obs_fix = W32_MIN[31:0];
    end else begin
      obs_fix = val_wide[31:0];
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_ch.kind;
      obs_r  <= obs_fix;
    end
  end

  // shared arithmetic
  always_comb begin
    obs_ext   = {obs_r[31], obs_r};
    x_ext     = {x_r[31], x_r};
    err       = obs_ext - x_ext;
    rst_den   = {1'b0, p0_r} + {1'b0, r_r};
    pp        = {1'b0, var_r} + {1'b0, q_r};
    obs_den   = {1'b0, pp} + {2'b00, r_r};
    prod_adj  = prod_r + (prod_r[65] ? RND_66 : 66'sd0);
    step_wide = prod_adj >>> FRAC_BITS;
    x_sum     = {x_r[31], x_r} + step_wide[32:0];
    pred_val  = ({{2{x_r[31]}}, x_r} <<< 1) - {{2{xp_r[31]}}, xp_r};
  end

  // multiplier operand select
  always_comb begin
    case (cw.mul)
      MUL_RP: begin
        mul_a = {1'b0, r_r};
        mul_b = {1'b0, p0_r};
      end
      MUL_EG: begin
        mul_a = err;
        mul_b = 33'({1'b0, gain_r});
      end
      MUL_RG: begin
        mul_a = {1'b0, r_r};
        mul_b = 33'({1'b0, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.mul != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // divider launch
  always_comb begin
    div_req.start = (cw.div != DIV_NONE);
    case (cw.div)
      DIV_RST: begin
        div_req.steps = DIV_STEPS_RST;
        div_hi        = {2'b00, prod_r[63:32]};
        div_lo        = prod_r[31:0];
        div_den       = {1'b0, rst_den};
      end
      DIV_OBS: begin
        div_req.steps = OBS_STEPS;
        div_hi        = {2'b00, pp[32:1]};
        div_lo        = {pp[0], 31'd0};
        div_den       = obs_den;
      end
      default: begin
        div_req.steps = '0;
        div_hi        = '0;
        div_lo        = '0;
        div_den       = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw.div == DIV_RST) begin
      den_zero_r <= (rst_den == '0);
    end else if (cw.div == DIV_OBS) begin
      den_zero_r <= (obs_den == '0);
    end
  end

  skf_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (div_req),
    .dividend_hi (div_hi),
    .dividend_lo (div_lo),
    .divisor     (div_den),
    .busy        (div_busy),
    .quotient    (div_quo)
  );

  // filter state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      xp_r  <= '0;
      var_r <= '0;
    end else begin
      case (cw.wr)
        WR_LOAD: begin
          x_r  <= obs_r;
          xp_r <= obs_r;
        end
        WR_VAR_DIV: var_r <= den_zero_r ? 32'd0 : div_quo;
        WR_EST: begin
          xp_r <= x_r;
          x_r  <= x_sum[31:0];
        end
        WR_VAR_MUL: var_r <= prod_r[FRAC_BITS +: 32];
        default: ;
      endcase
    end
  end

  // gain and prediction working registers
  always_ff @(posedge clk) begin
    if (cw.wr == WR_GAIN) begin
      gain_r <= den_zero_r ? '0 : div_quo[GAIN_W-1:0];
    end
    if (cw.wr == WR_PRED) begin
      pred_r <= pred_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.wr == WR_OUT && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.wr == WR_OUT && !out_busy) begin
      out_est_r  <= to_out({{2{x_r[31]}}, x_r});
      out_pred_r <= to_out(pred_r);
    end
  end

  assign in_ch.ready       = cw.accept;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.estimate   = out_est_r;
  assign out_ch.prediction = out_pred_r;

endmodule

// ===== rtl/core/skf_checker.sv =====
// skf_checker: port-level assertions for the scalar kalman filter, bound to the top level
// depends on scalar_kalman_filter for the bind target
module skf_checker #(
  parameter int VALUE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] out_est,
  input logic signed [VALUE_BITS-1:0] out_pred
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  // items in flight: one at work plus one waiting result at most
  always_comb begin
    in_acc  = in_valid && in_ready;
    out_acc = out_valid && out_ready;
    cnt_nxt = cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_est) && $stable(out_pred))
    else $error("result payload changed while stalled");

  // an accepted item occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second item taken while one is at work");

  // never more than two items in flight
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("too many items in flight");

  // no result without an item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 2'd0)
    else $error("result offered with no item accepted");

endmodule

bind scalar_kalman_filter skf_checker #(.VALUE_BITS(VALUE_BITS)) u_skf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_est   (out_ch.estimate),
  .out_pred  (out_ch.prediction)
);
